>>> hdl/cto_pkg.sv
// ----------------------------------------------------------------------------
// cto_pkg: shared constants and types for the coplanar triangle overlap block
// Widths of coordinates, products and the controller-datapath command word.
// ----------------------------------------------------------------------------
package cto_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int ACC_WIDTH   = PROD_WIDTH + 1;
    localparam int SUM_WIDTH   = ACC_WIDTH + 1;
    localparam int EPS_WIDTH   = 48;
    localparam int NUM_SLOTS   = 7;
    localparam int SLOT_WIDTH  = 3;

    // datapath operations, one per step
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_AXIS  = 3'd1;
    localparam logic [2:0] OP_PAIR  = 3'd2;
    localparam logic [2:0] OP_SIDE  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] e0;    // edge start index, first triangle of the pair
        logic [1:0] q0;    // edge start index on the other triangle
        logic       swap;  // side test: point from tri one against tri two
        logic [1:0] k;     // side edge / phase
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic contain;
    } t_stat;

endpackage

>>> hdl/coplanar_triangle_overlap.sv
// Throughput: one point word a cycle while o_ready is high; a test holds off
// input through axis choice, every edge pair, the side functions of both
// triangles, an evaluation step and an output load, longer while the previous
// overlap word still waits in the output register.
// Reset (i_rst_n, synchronous) clears control and the tolerance; points are
// undefined until written.
// ----------------------------------------------------------------------------
// coplanar_triangle_overlap: area overlap of two coplanar triangles
// Stores seven points, then runs the projected edge and containment tests.
// ----------------------------------------------------------------------------
module coplanar_triangle_overlap import cto_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [EPS_WIDTH-1:0]          i_touch_epsilon,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [SLOT_WIDTH-1:0]         i_slot,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_overlap
);

    logic [EPS_WIDTH-1:0] r_eps;
    logic  w_busy, w_acc;
    t_cmd  w_cmd;
    t_stat w_stat;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_eps <= '0;
        else if (i_cfg_valid) r_eps <= i_touch_epsilon;
    end
    assign o_cfg_ready = 1'b1;

    assign o_ready = !w_busy;
    assign w_acc   = i_valid && !w_busy;

    cto_datapath u_dp (
        .i_clk  (i_clk),
        .i_wr   (w_acc),
        .i_slot (i_slot),
        .i_x    (i_coord_x),
        .i_y    (i_coord_y),
        .i_z    (i_coord_z),
        .i_eps  (r_eps),
        .i_cmd  (w_cmd),
        .o_stat (w_stat)
    );

    cto_control u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_acc && i_last),
        .i_stat      (w_stat),
        .i_out_ready (i_ready),
        .o_busy      (w_busy),
        .o_cmd       (w_cmd),
        .o_out_valid (o_valid),
        .o_overlap   (o_overlap)
    );

endmodule

>>> hdl/cto_datapath.sv
// ----------------------------------------------------------------------------
// cto_datapath: point store, axis projection and a shared bank of six products
// Each pair or side command evaluates one edge pair or one point-side function.
// ----------------------------------------------------------------------------
module cto_datapath import cto_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_wr,
    input  logic [SLOT_WIDTH-1:0]         i_slot,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic signed [COORD_WIDTH-1:0] i_z,
    input  logic [EPS_WIDTH-1:0]          i_eps,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat
);

    logic signed [COORD_WIDTH-1:0] r_px [NUM_SLOTS];
    logic signed [COORD_WIDTH-1:0] r_py [NUM_SLOTS];
    logic signed [COORD_WIDTH-1:0] r_pz [NUM_SLOTS];
    logic [1:0] r_axis;  // 0: keep y,z  1: keep x,y  2: keep x,z
    logic r_hit, r_inside;
    logic signed [1:0] r_s0;

    // point store
    always_ff @(posedge i_clk) begin
        if (i_wr && i_slot < SLOT_WIDTH'(NUM_SLOTS)) begin
            r_px[i_slot] <= i_x;
            r_py[i_slot] <= i_y;
            r_pz[i_slot] <= i_z;
        end
    end

    // axis choice from the normal
    logic [COORD_WIDTH:0] w_nx, w_ny, w_nz;
    logic [1:0] w_axis;
    always_comb begin
        w_nx = r_px[6][COORD_WIDTH-1] ? -{r_px[6][COORD_WIDTH-1], r_px[6]}
                                      :  {r_px[6][COORD_WIDTH-1], r_px[6]};
        w_ny = r_py[6][COORD_WIDTH-1] ? -{r_py[6][COORD_WIDTH-1], r_py[6]}
                                      :  {r_py[6][COORD_WIDTH-1], r_py[6]};
        w_nz = r_pz[6][COORD_WIDTH-1] ? -{r_pz[6][COORD_WIDTH-1], r_pz[6]}
                                      :  {r_pz[6][COORD_WIDTH-1], r_pz[6]};
        if (w_nx > w_ny) w_axis = (w_nx > w_nz) ? 2'd0 : 2'd1;
        else             w_axis = (w_nz > w_ny) ? 2'd1 : 2'd2;
    end

    function automatic logic signed [COORD_WIDTH-1:0] pu(input logic [2:0] s,
                                                         input logic [1:0] ax);
        logic signed [COORD_WIDTH-1:0] v;
        v = (ax == 2'd0) ? r_py[s] : r_px[s];
        return v;
    endfunction
    function automatic logic signed [COORD_WIDTH-1:0] pv(input logic [2:0] s,
                                                         input logic [1:0] ax);
        logic signed [COORD_WIDTH-1:0] v;
        v = (ax == 2'd1) ? r_py[s] : r_pz[s];
        return v;
    endfunction

    // operand selection
    logic [2:0] w_p0, w_p1, w_q0, w_q1, w_pt;
    logic signed [DIFF_WIDTH-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy;
    always_comb begin
        w_p0 = {1'b0, i_cmd.e0};
        w_p1 = (i_cmd.e0 == 2'd2) ? 3'd0 : {1'b0, i_cmd.e0 + 2'd1};
        w_q0 = 3'd3 + {1'b0, i_cmd.q0};
        w_q1 = (i_cmd.q0 == 2'd2) ? 3'd3 : 3'd4 + {1'b0, i_cmd.q0};
        w_pt = 3'd0;
        if (i_cmd.op == OP_SIDE) begin
            // edge k of the tested triangle, point 0 of the other
            if (i_cmd.swap) begin
                w_pt = 3'd0;
                w_q0 = 3'd3 + {1'b0, i_cmd.k};
                w_q1 = (i_cmd.k == 2'd2) ? 3'd3 : 3'd4 + {1'b0, i_cmd.k};
            end else begin
                w_pt = 3'd3;
                w_q0 = {1'b0, i_cmd.k};
                w_q1 = (i_cmd.k == 2'd2) ? 3'd0 : {1'b0, i_cmd.k + 2'd1};
            end
        end
        w_ax = DIFF_WIDTH'(pu(w_p1, r_axis)) - DIFF_WIDTH'(pu(w_p0, r_axis));
        w_ay = DIFF_WIDTH'(pv(w_p1, r_axis)) - DIFF_WIDTH'(pv(w_p0, r_axis));
        w_bx = DIFF_WIDTH'(pu(w_q0, r_axis)) - DIFF_WIDTH'(pu(w_q1, r_axis));
        w_by = DIFF_WIDTH'(pv(w_q0, r_axis)) - DIFF_WIDTH'(pv(w_q1, r_axis));
        if (i_cmd.op == OP_SIDE) begin
            w_cx = DIFF_WIDTH'(pu(w_pt, r_axis)) - DIFF_WIDTH'(pu(w_q0, r_axis));
            w_cy = DIFF_WIDTH'(pv(w_pt, r_axis)) - DIFF_WIDTH'(pv(w_q0, r_axis));
        end else begin
            w_cx = DIFF_WIDTH'(pu(w_p0, r_axis)) - DIFF_WIDTH'(pu(w_q0, r_axis));
            w_cy = DIFF_WIDTH'(pv(w_p0, r_axis)) - DIFF_WIDTH'(pv(w_q0, r_axis));
        end
    end

    // products: f, d, e for a pair; the side function uses the d pair
    logic signed [PROD_WIDTH-1:0] r_m [6];
    logic [2:0] r_op;
    logic [1:0] r_k;
    always_ff @(posedge i_clk) begin
        r_m[0] <= w_ay * w_bx;
        r_m[1] <= w_ax * w_by;
        r_m[2] <= w_by * w_cx;
        r_m[3] <= w_bx * w_cy;
        r_m[4] <= w_ax * w_cy;
        r_m[5] <= w_ay * w_cx;
        r_op   <= i_cmd.op;
        r_k    <= i_cmd.k;
    end

    // evaluate the products
    logic signed [ACC_WIDTH-1:0] w_f, w_d, w_e;
    logic signed [SUM_WIDTH-1:0] w_df, w_ef;
    logic w_dz, w_dn, w_ez, w_en, w_pair, w_ind, w_inf;
    logic signed [1:0] w_sg;
    function automatic logic near0(input logic signed [SUM_WIDTH-1:0] v,
                                   input logic [EPS_WIDTH-1:0] eps);
        logic [SUM_WIDTH-1:0] m;
        m = v[SUM_WIDTH-1] ? SUM_WIDTH'(-v) : SUM_WIDTH'(v);
        return m <= SUM_WIDTH'(eps);
    endfunction
    always_comb begin
        w_f  = ACC_WIDTH'(r_m[0]) - ACC_WIDTH'(r_m[1]);
        w_d  = ACC_WIDTH'(r_m[2]) - ACC_WIDTH'(r_m[3]);
        w_e  = ACC_WIDTH'(r_m[4]) - ACC_WIDTH'(r_m[5]);
        w_df = SUM_WIDTH'(w_d) - SUM_WIDTH'(w_f);
        w_ef = SUM_WIDTH'(w_e) - SUM_WIDTH'(w_f);
        w_dz = near0(SUM_WIDTH'(w_d), i_eps);
        w_dn = near0(w_df, i_eps);
        w_ez = near0(SUM_WIDTH'(w_e), i_eps);
        w_en = near0(w_ef, i_eps);
        if (w_f > 0) begin
            w_ind = (w_d >= 0) && (w_d <= w_f);
            w_inf = (w_e >= 0) && (w_e <= w_f);
        end else if (w_f < 0) begin
            w_ind = (w_d <= 0) && (w_d >= w_f);
            w_inf = (w_e <= 0) && (w_e >= w_f);
        end else begin
            w_ind = 1'b0;
            w_inf = 1'b0;
        end
        w_pair = w_ind && w_inf && !((w_dz || w_dn) && (w_ez || w_en));
        // side function: -(by*cx - bx*cy) matches the edge normal form
        w_sg = (w_d < 0) ? 2'sd1 : (w_d > 0) ? -2'sd1 : 2'sd0;
    end

    // result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_AXIS) r_axis <= w_axis;
        if (i_cmd.op == OP_CLEAR) begin
            r_hit    <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            case (r_op)
                OP_PAIR: if (w_pair) r_hit <= 1'b1;
                OP_SIDE: begin
                    if (r_k == 2'd0) r_s0 <= w_sg;
                    else if (w_sg == 2'sd0 || w_sg != r_s0) r_s0 <= 2'sd0;
                    else if (r_k == 2'd2 && r_s0 != 2'sd0) r_inside <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.hit     = r_hit;
    assign o_stat.contain = r_inside;

endmodule

>>> hdl/cto_control.sv
// ----------------------------------------------------------------------------
// cto_control: sequencer for one overlap test
// Steps axis choice, all edge pairs and the side functions, then offers the word.
// ----------------------------------------------------------------------------
module cto_control import cto_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    input  logic  i_out_ready,
    output logic  o_busy,
    output t_cmd  o_cmd,
    output logic  o_out_valid,
    output logic  o_overlap
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AXIS = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [3:0] r_step, n_step;   // 0-8 pairs, 9-14 side functions
    logic r_valid, n_valid, r_ovl, n_ovl;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_valid = r_valid;
        n_ovl   = r_ovl;
        o_cmd   = '0;
        if (r_valid && i_out_ready) n_valid = 1'b0;
        case (r_state)
            S_IDLE: if (i_start) begin
                o_cmd.op = OP_CLEAR;
                n_state  = S_AXIS;
            end
            S_AXIS: begin
                o_cmd.op = OP_AXIS;
                n_step   = 4'd0;
                n_state  = S_RUN;
            end
            S_RUN: begin
                if (r_step < 4'd9) begin
                    o_cmd.op = OP_PAIR;
                    o_cmd.e0 = (r_step < 4'd3) ? 2'd0 : (r_step < 4'd6) ? 2'd1 : 2'd2;
                    o_cmd.q0 = (r_step < 4'd3) ? r_step[1:0]
                             : (r_step < 4'd6) ? 2'(r_step - 4'd3) : 2'(r_step - 4'd6);
                end else begin
                    o_cmd.op   = OP_SIDE;
                    o_cmd.swap = (r_step >= 4'd12);
                    o_cmd.k    = (r_step < 4'd12) ? 2'(r_step - 4'd9) : 2'(r_step - 4'd12);
                end
                n_step = r_step + 4'd1;
                if (r_step == 4'd14) n_state = S_WAIT;
            end
            S_WAIT: n_state = S_OUT;
            S_OUT: if (!r_valid || i_out_ready) begin
                n_valid = 1'b1;
                n_ovl   = i_stat.hit || i_stat.contain;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
        r_ovl <= n_ovl;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_valid;
    assign o_overlap   = r_ovl;

endmodule
